@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/dfip_pkg.sv @@
`timescale 1ns / 1ps

package dfip_pkg;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 7;
    localparam int VALUE_W = 32;
    localparam int KEPT_W  = 4;

    localparam int MAX_KEPT_DEFAULT = 10;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [CHAR_W-1:0] DELIM_RESET = 8'h2C;

    // saturation limits of the magnitude
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_VALUE    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_in;
        logic [INDEX_W-1:0] field_index;
        logic               last;
    } t_in_item;

    typedef struct packed {
        t_status                    status;
        logic signed [VALUE_W-1:0]  value;
        logic [KEPT_W-1:0]          kept_count;
        logic                       overflow;
    } t_out_item;

endpackage

@@ src/dfip_scan.sv @@
`timescale 1ns / 1ps

module dfip_scan #(
    parameter int MAX_KEPT = dfip_pkg::MAX_KEPT_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  dfip_pkg::t_in_item               i_item,
    input  logic [dfip_pkg::CHAR_W-1:0]      i_delimiter,
    output logic                             o_push,
    output dfip_pkg::t_out_item              o_result
);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SEEK  = 2'd1,
        PH_FIELD = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    localparam logic [1:0] CONV_SIGN = 2'd0;
    localparam logic [1:0] CONV_NUM  = 2'd1;
    localparam logic [1:0] CONV_STOP = 2'd2;

    localparam logic [dfip_pkg::KEPT_W-1:0] MAX_KEPT_K = dfip_pkg::KEPT_W'(MAX_KEPT);
    localparam int PROD_W = dfip_pkg::VALUE_W + 4;

    t_phase                             r_phase, n_phase;
    logic [dfip_pkg::INDEX_W-1:0]       r_target, n_target;
    logic [dfip_pkg::INDEX_W-1:0]       r_delims, n_delims;
    logic [dfip_pkg::KEPT_W-1:0]        r_kept, n_kept;
    logic [1:0]                         r_conv, n_conv;
    logic                               r_neg, n_neg;
    logic [dfip_pkg::VALUE_W-1:0]       r_acc, n_acc;
    logic                               r_sat, n_sat;
    dfip_pkg::t_status                  r_status, n_status;

    logic [dfip_pkg::CHAR_W-1:0]        c;
    logic                               is_digit;
    logic                               is_delim_end;
    logic                               is_drop;
    logic                               is_minus;
    logic                               field_go;
    logic [PROD_W-1:0]                  prod;
    logic [dfip_pkg::VALUE_W-1:0]       limit;

    assign c            = i_item.char_in;
    assign is_digit     = (c >= dfip_pkg::CH_ZERO) && (c <= dfip_pkg::CH_NINE);
    assign is_minus     = (c == dfip_pkg::CH_MINUS);
    assign is_drop      = (c == dfip_pkg::CH_SPACE) || (c == dfip_pkg::CH_DOT);
    assign is_delim_end = (c == i_delimiter) || (c == dfip_pkg::CH_NUL);

    // accumulator times ten plus the digit, as shift-add
    assign prod  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                 + {{(PROD_W-4){1'b0}}, c[3:0]};
    assign limit = r_neg ? dfip_pkg::NEG_LIMIT : dfip_pkg::POS_LIMIT;

    // next line state for one character
    always_comb begin
        n_phase  = r_phase;
        n_target = r_target;
        n_delims = r_delims;
        n_kept   = r_kept;
        n_conv   = r_conv;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_status = r_status;
        field_go = 1'b0;

        // first character of a line samples the wanted field
        if (r_phase == PH_START) begin
            n_target = i_item.field_index;
            n_delims = '0;
            n_phase  = PH_SEEK;
        end

        // delimiter counting
        if (n_phase == PH_SEEK) begin
            if (c == dfip_pkg::CH_NUL) begin
                n_status = dfip_pkg::ST_NOTFOUND;
                n_phase  = PH_DONE;
            end else if (n_delims == n_target) begin
                if (c == i_delimiter) begin
                    n_status = dfip_pkg::ST_EMPTY;
                    n_phase  = PH_DONE;
                end else begin
                    n_status = dfip_pkg::ST_VALUE;
                    n_phase  = PH_FIELD;
                    field_go = 1'b1;
                end
            end else if (c == i_delimiter) begin
                n_delims = n_delims + 1'b1;
            end
        end else if (n_phase == PH_FIELD) begin
            field_go = 1'b1;
        end

        // character inside the wanted field
        if (field_go) begin
            if (is_delim_end) begin
                n_phase = PH_DONE;
            end else if (!is_digit && !is_minus && !is_drop) begin
                n_status = dfip_pkg::ST_INVALID;
                n_phase  = PH_DONE;
            end else if (!is_drop) begin
                n_kept = r_kept + 1'b1;
                if (is_minus) begin
                    if (r_conv == CONV_SIGN) begin
                        n_neg  = 1'b1;
                        n_conv = CONV_NUM;
                    end else begin
                        n_conv = CONV_STOP;
                    end
                end else if (r_conv != CONV_STOP) begin
                    if (prod > {4'd0, limit}) begin
                        n_acc = limit;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = prod[dfip_pkg::VALUE_W-1:0];
                    end
                    n_conv = CONV_NUM;
                end
                if (n_kept >= MAX_KEPT_K) begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    // result of the line on its final character
    always_comb begin
        o_push   = i_accept && i_item.last;
        o_result = '0;
        o_result.status = n_status;
        if (n_status == dfip_pkg::ST_VALUE) begin
            o_result.value      = n_neg ? -n_acc : n_acc;
            o_result.kept_count = n_kept;
            o_result.overflow   = n_sat;
        end
    end

    // line state, cleared at reset and after each line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last)) begin
            r_phase  <= PH_START;
            r_target <= '0;
            r_delims <= '0;
            r_kept   <= '0;
            r_conv   <= CONV_SIGN;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_sat    <= 1'b0;
            r_status <= dfip_pkg::ST_NOTFOUND;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_target <= n_target;
            r_delims <= n_delims;
            r_kept   <= n_kept;
            r_conv   <= n_conv;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_sat    <= n_sat;
            r_status <= n_status;
        end
    end

endmodule

@@ src/dfip_out_buf.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dfip_out_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  dfip_pkg::t_out_item    i_result,
    output logic                   o_full,
    output logic                   o_valid,
    input  logic                   i_stall,
    output dfip_pkg::t_out_item    o_result
);

    dfip_pkg::t_out_item r_data [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_data[r_rd_ptr];
    assign pop      = o_valid && !i_stall;

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_result;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    // a result never lands in a full queue
    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, r_count != 2'd2)
    // count follows a push without a transfer out
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !pop, r_count == $past(r_count) + 2'd1)
    // pointers differ exactly when one entry is held
    `ASSERT_IMPLIES(a_ptr_match, i_clk, i_rst_n, r_count == 2'd1, r_wr_ptr != r_rd_ptr)

endmodule

@@ src/delimited_field_int_parser_top.sv @@
`timescale 1ns / 1ps

// Takes and parses one character per cycle while o_in_stall is low and picks one integer
// field out of a delimited line. The result of a line is written into the result queue
// as its last character is taken, and the per-character update (delimiter count,
// character check, multiply-by-ten-add with saturation) is combinational. A two-entry
// result queue sits on the output, so characters keep flowing while one result waits;
// o_in_stall rises only when both entries hold untaken results. The delimiter register
// may be written whenever the block is idle and is always ready.
module delimited_field_int_parser_top #(
    parameter int MAX_KEPT = dfip_pkg::MAX_KEPT_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dfip_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dfip_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dfip_pkg::CHAR_W-1:0]   i_cfg_data
);

    logic [dfip_pkg::CHAR_W-1:0] r_delimiter;
    logic                        in_accept;
    logic                        push;
    dfip_pkg::t_out_item         result;
    logic                        full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign in_accept   = i_in_valid && !full;

    // delimiter register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter <= dfip_pkg::DELIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_delimiter <= i_cfg_data;
        end
    end

    // character scan and conversion
    dfip_scan #(
        .MAX_KEPT (MAX_KEPT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .i_delimiter (r_delimiter),
        .o_push      (push),
        .o_result    (result)
    );

    // result queue
    dfip_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (o_out_data)
    );

endmodule

@@ test/delimited_field_int_parser_top_test.sv @@
`timescale 1ns / 1ps

module delimited_field_int_parser_top_test;

    localparam int KEEP_LIMIT   = dfip_pkg::MAX_KEPT_DEFAULT;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 30;
    localparam int HOLD_CYCLES  = 90;

    typedef enum logic [1:0] {
        SCAN_START = 2'd0,
        SCAN_SEEK  = 2'd1,
        SCAN_FIELD = 2'd2,
        SCAN_DONE  = 2'd3
    } t_scan;

    typedef enum logic [1:0] {
        CONV_START   = 2'd0,
        CONV_DIGITS  = 2'd1,
        CONV_STOPPED = 2'd2
    } t_conv;

    typedef enum logic [1:0] {
        STALL_NONE   = 2'd0,
        STALL_HALF   = 2'd1,
        STALL_SPARSE = 2'd2
    } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    dfip_pkg::t_in_item   i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    dfip_pkg::t_out_item  o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [dfip_pkg::CHAR_W-1:0] i_cfg_data = '0;

    // field parser state as the block should hold it
    logic [dfip_pkg::CHAR_W-1:0]  cur_delim = dfip_pkg::DELIM_RESET;
    logic [dfip_pkg::INDEX_W-1:0] want_field = '0;
    logic [dfip_pkg::INDEX_W-1:0] delim_count = '0;
    t_scan                        scan = SCAN_START;
    logic [dfip_pkg::KEPT_W-1:0]  kept_n = '0;
    t_conv                        conv = CONV_START;
    logic                         is_neg = 1'b0;
    logic [dfip_pkg::VALUE_W-1:0] magnitude = '0;
    logic                         clipped = 1'b0;
    dfip_pkg::t_status            line_stat = dfip_pkg::ST_NOTFOUND;

    dfip_pkg::t_out_item line_results_due [$];
    dfip_pkg::t_in_item  pending_chars [$];
    logic [7:0]  line_chars [$];
    int          queued_total = 0;
    int          accepted_total = 0;
    int          error_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          next_hold_at = 150;
    int          mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          cycle_count = 0;

    delimited_field_int_parser_top #(
        .MAX_KEPT(KEEP_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one character inside the wanted field
    function automatic void field_char_step(logic [7:0] c);
        logic [dfip_pkg::VALUE_W-1:0] limit;
        logic [63:0]                  widened;
        if (c == cur_delim || c == dfip_pkg::CH_NUL) begin
            scan = SCAN_DONE;
        end else if (!(c >= dfip_pkg::CH_ZERO && c <= dfip_pkg::CH_NINE)
                     && c != dfip_pkg::CH_MINUS && c != dfip_pkg::CH_SPACE
                     && c != dfip_pkg::CH_DOT) begin
            line_stat = dfip_pkg::ST_INVALID;
            scan = SCAN_DONE;
        end else if (c != dfip_pkg::CH_SPACE && c != dfip_pkg::CH_DOT) begin
            kept_n++;
            if (c == dfip_pkg::CH_MINUS) begin
                // only a leading minus is a sign, any later one ends the number
                if (conv == CONV_START) begin
                    is_neg = 1'b1;
                    conv = CONV_DIGITS;
                end else begin
                    conv = CONV_STOPPED;
                end
            end else if (conv != CONV_STOPPED) begin
                limit = is_neg ? dfip_pkg::NEG_LIMIT : dfip_pkg::POS_LIMIT;
                widened = {32'd0, magnitude} * 64'd10
                        + {56'd0, 8'(c - dfip_pkg::CH_ZERO)};
                if (widened > {32'd0, limit}) begin
                    magnitude = limit;
                    clipped = 1'b1;
                end else begin
                    magnitude = widened[31:0];
                end
                conv = CONV_DIGITS;
            end
            if (kept_n >= KEEP_LIMIT)
                scan = SCAN_DONE;
        end
    endfunction

    // advance the line state by one accepted character, queue the line result at its end
    function automatic void parse_char(dfip_pkg::t_in_item it);
        dfip_pkg::t_out_item res;
        if (scan == SCAN_START) begin
            want_field = it.field_index;
            delim_count = '0;
            scan = SCAN_SEEK;
        end
        if (scan == SCAN_SEEK) begin
            if (it.char_in == dfip_pkg::CH_NUL) begin
                line_stat = dfip_pkg::ST_NOTFOUND;
                scan = SCAN_DONE;
            end else if (delim_count == want_field) begin
                if (it.char_in == cur_delim) begin
                    line_stat = dfip_pkg::ST_EMPTY;
                    scan = SCAN_DONE;
                end else begin
                    line_stat = dfip_pkg::ST_VALUE;
                    scan = SCAN_FIELD;
                    field_char_step(it.char_in);
                end
            end else if (it.char_in == cur_delim) begin
                delim_count++;
            end
        end else if (scan == SCAN_FIELD) begin
            field_char_step(it.char_in);
        end
        if (it.last) begin
            res = '0;
            res.status = line_stat;
            if (line_stat == dfip_pkg::ST_VALUE) begin
                res.value = is_neg ? 32'd0 - magnitude : magnitude;
                res.kept_count = kept_n;
                res.overflow = clipped;
            end
            line_results_due.push_back(res);
            want_field = '0;
            delim_count = '0;
            scan = SCAN_START;
            kept_n = '0;
            conv = CONV_START;
            is_neg = 1'b0;
            magnitude = '0;
            clipped = 1'b0;
            line_stat = dfip_pkg::ST_NOTFOUND;
        end
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // line building
    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endtask

    task automatic send_line(int first_index);
        dfip_pkg::t_in_item it;
        foreach (line_chars[i]) begin
            it.char_in = line_chars[i];
            it.field_index = (i == 0) ? 7'(first_index) : 7'($urandom_range(0, 127));
            it.last = (i == line_chars.size() - 1);
            pending_chars.push_back(it);
            queued_total++;
        end
        line_chars.delete();
    endtask

    task automatic add_number(int max_digits);
        int n_digits;
        if ($urandom_range(0, 3) == 0)
            line_chars.push_back(dfip_pkg::CH_SPACE);
        if ($urandom_range(0, 2) == 0)
            line_chars.push_back(dfip_pkg::CH_MINUS);
        n_digits = $urandom_range(1, max_digits);
        for (int i = 0; i < n_digits; i++) begin
            line_chars.push_back(8'(dfip_pkg::CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 11) == 0)
                line_chars.push_back($urandom_range(0, 1) ? dfip_pkg::CH_DOT
                                                         : dfip_pkg::CH_SPACE);
        end
    endtask

    task automatic add_field();
        case ($urandom_range(0, 9))
            0: ;
            1: begin
                // number broken by a letter or a high byte
                add_number(4);
                line_chars.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                                         : 8'($urandom_range(8'h80, 8'hFF)));
                add_number(2);
            end
            2: begin
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 2))
                        0: line_chars.push_back(dfip_pkg::CH_SPACE);
                        1: line_chars.push_back(dfip_pkg::CH_DOT);
                        default: line_chars.push_back(dfip_pkg::CH_MINUS);
                    endcase
                end
            end
            3: add_number(12);
            4: begin
                add_number(3);
                line_chars.push_back(dfip_pkg::CH_MINUS);
                add_number(3);
            end
            default: add_number(6);
        endcase
    endtask

    task automatic add_random_line();
        int n_fields;
        int target;
        if ($urandom_range(0, 4) == 0) begin
            // raw byte noise
            repeat ($urandom_range(1, 6))
                line_chars.push_back(8'($urandom_range(0, 255)));
            send_line($urandom_range(0, 3));
        end else begin
            n_fields = $urandom_range(1, 5);
            for (int f = 0; f < n_fields; f++) begin
                if (f != 0)
                    line_chars.push_back(cur_delim);
                add_field();
            end
            if (line_chars.size() == 0)
                line_chars.push_back(cur_delim);
            target = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, n_fields - 1);
            send_line(target);
        end
    endtask

    task automatic wait_idle();
        while (accepted_total != queued_total || line_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delimiter(logic [7:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_delim = d;
        i_cfg_valid <= 1'b0;
    endtask

    // character sender: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                parse_char(i_in_data);
                accepted_total++;
            end
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_chars.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    // result receiver stall pattern, with long hold-offs to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (accepted_total >= next_hold_at) begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 250;
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(5, 60);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE: i_out_stall <= 1'b0;
                    STALL_HALF: i_out_stall <= 1'($urandom_range(0, 1));
                    default:    i_out_stall <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // compare each result transfer with the oldest line result due
    always @(posedge i_clk) begin
        dfip_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (line_results_due.size() == 0) begin
                $display("%0t unexpected result: expected none actual status %0d value %0d",
                         $time, o_out_data.status, o_out_data.value);
                error_count++;
            end else begin
                want = line_results_due.pop_front();
                check_field("status", want.status, o_out_data.status);
                check_field("value", want.value, o_out_data.value);
                check_field("kept_count", want.kept_count, o_out_data.kept_count);
                check_field("overflow", want.overflow, o_out_data.overflow);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL delimited_field_int_parser_top");
        $finish;
    end

    initial begin
        logic [7:0] delim_plan [$];
        int phase_start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines with the reset delimiter
        add_text("123");         send_line(0);
        add_text("-214748364");  send_line(0);
        add_text("2147483647");  send_line(0);
        add_text("2147483648");  send_line(0);
        add_text("99999999999"); send_line(0);
        add_text("1,,3");        send_line(1);
        add_text("1,2");         send_line(5);
        add_text("a,12");        send_line(1);
        add_text("1 2.3");       send_line(0);
        add_text("12x4");        send_line(0);
        add_text("--5");         send_line(0);
        add_text("5-3");         send_line(0);
        add_text(" . -");        send_line(0);
        add_text("7,8,9");       send_line(2);
        add_text("12");
        line_chars.push_back(dfip_pkg::CH_NUL);
        add_text("34");          send_line(0);
        add_text("1");
        line_chars.push_back(dfip_pkg::CH_NUL);
        add_text(",5");          send_line(1);
        add_text("1234567890x"); send_line(0);
        add_text(",");           send_line(0);
        add_text("0");           send_line(127);
        add_text("-0");          send_line(0);
        add_text("x");           send_line(0);
        add_text("0000000001");  send_line(0);

        // highest field index actually reached
        repeat (127) line_chars.push_back(cur_delim);
        add_text("42");
        send_line(127);

        phase_start = queued_total;
        while (queued_total - phase_start < PHASE_ITEMS)
            add_random_line();
        wait_idle();

        // NUL, all ones, a digit, the sign, space, dot, random, then back to comma
        delim_plan = {8'h00, 8'hFF, 8'h35, dfip_pkg::CH_MINUS, dfip_pkg::CH_SPACE,
                      dfip_pkg::CH_DOT, 8'($urandom_range(1, 254)), dfip_pkg::DELIM_RESET};
        foreach (delim_plan[p]) begin
            write_delimiter(delim_plan[p]);
            if (delim_plan[p] == 8'h35) begin
                add_text("153"); send_line(1);
                add_text("5");   send_line(0);
            end
            phase_start = queued_total;
            while (queued_total - phase_start < PHASE_ITEMS)
                add_random_line();
            wait_idle();
        end

        if (error_count == 0)
            $display("PASS delimited_field_int_parser_top");
        else
            $display("FAIL delimited_field_int_parser_top");
        $finish;
    end

endmodule
